// ===== sv/rct_pkg.sv =====
// ----------------------------------------------------------------------------
// Root counter timer package
// Shared operation codes, mode word bit positions and fixed constants.
// ----------------------------------------------------------------------------
package rct_pkg;

  localparam int unsigned NUM_CH = 3;

  // Channel code that addresses no timer.
  localparam logic [1:0] CH_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    OP_TICK         = 3'd0,
    OP_WRITE_COUNT  = 3'd1,
    OP_WRITE_MODE   = 3'd2,
    OP_WRITE_TARGET = 3'd3,
    OP_READ_COUNT   = 3'd4,
    OP_READ_MODE    = 3'd5,
    OP_READ_TARGET  = 3'd6
  } op_t;

  // Mode word bit positions.
  localparam int unsigned MB_DISABLE    = 0;
  localparam int unsigned MB_TO_TARGET  = 3;
  localparam int unsigned MB_IRQ_TARGET = 4;
  localparam int unsigned MB_IRQ_OVF    = 5;
  localparam int unsigned MB_REGEN      = 6;
  localparam int unsigned MB_RATE0      = 8;
  localparam int unsigned MB_RATE2      = 9;
  localparam int unsigned MB_EVENT      = 10;
  localparam int unsigned MB_EQ_TARGET  = 11;
  localparam int unsigned MB_OVERFLOW   = 12;

  // A mode read clears the two sticky status bits.
  localparam logic [15:0] MODE_READ_CLEAR = 16'he7ff;

  localparam logic [15:0] RATE_CH0_DIV = 16'd5;
  localparam logic [15:0] RATE_CH2_DIV = 16'd8;
  localparam logic [15:0] HSYNC_DIV_RESET = 16'd2146;

endpackage

// ===== sv/rct_if.sv =====
// ----------------------------------------------------------------------------
// Root counter timer channel interfaces
// Valid/ready channels for register accesses, results and configuration.
// ----------------------------------------------------------------------------
interface rct_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [1:0]  channel;
  logic [15:0] write_value;

  modport source (output valid, output op, output channel, output write_value, input ready);
  modport sink   (input valid, input op, input channel, input write_value, output ready);
endinterface

interface rct_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [2:0]  irq_pulses;

  modport source (output valid, output read_data, output irq_pulses, input ready);
  modport sink   (input valid, input read_data, input irq_pulses, output ready);
endinterface

interface rct_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/root_counter_timer_block_top.sv =====
// ----------------------------------------------------------------------------
// Root counter timer block
// Three timer channels with prescalers, targets, sticky status and interrupts.
// ----------------------------------------------------------------------------
// An accepted beat is held in the input register, processed from there, and
// its result is written into the result register, where it stays until taken.
// Throughput: one beat per cycle while results drain; the two registers keep
// both sides moving, and a stalled result holds the input beat in place.
// Reset (rst_n, synchronous, active low) clears all channel state, empties
// both registers and loads the hsync divider with 2146.
module root_counter_timer_block_top #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  rct_in_if.sink    in_ch,
  rct_out_if.source out_ch,
  rct_cfg_if.sink   cfg_ch
);
  import rct_pkg::*;

  // The count register is at least 16 bits wide: with a narrow count and a
  // target above the wrap point, the count runs on up to the target before
  // it wraps, exactly as the channel behavior defines it.
  localparam int unsigned VW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [VW:0]   LIMIT = {{VW{1'b0}}, 1'b1} << COUNT_BITS;
  localparam logic [VW:0]   LIMIT_M1 = LIMIT - {{VW{1'b0}}, 1'b1};
  localparam logic [VW-1:0] CNT_MASK = LIMIT_M1[VW-1:0];

  // Channel state.
  logic [VW-1:0] count_r     [NUM_CH];
  logic [15:0]   phase_r     [NUM_CH];
  logic [15:0]   mode_r      [NUM_CH];
  logic [15:0]   target_r    [NUM_CH];
  logic          toward_r    [NUM_CH];
  logic          fired_r     [NUM_CH];

  logic [VW-1:0] count_nxt   [NUM_CH];
  logic [15:0]   phase_nxt   [NUM_CH];
  logic [15:0]   mode_nxt    [NUM_CH];
  logic [15:0]   target_nxt  [NUM_CH];
  logic          toward_nxt  [NUM_CH];
  logic          fired_nxt   [NUM_CH];

  logic [15:0]   hsync_div_r;

  // Input register.
  logic          s1_valid_r;
  logic [2:0]    s1_op_r;
  logic [1:0]    s1_channel_r;
  logic [15:0]   s1_wval_r;

  // Result register.
  logic          out_valid_r;
  logic [15:0]   out_rdata_r;
  logic [2:0]    out_irq_r;
  logic [15:0]   rdata_nxt;
  logic [2:0]    irq_nxt;

  logic          advance;

  // The result register moves whenever it is empty or being drained; the
  // input register then hands its beat over in the same cycle.
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_data  = out_rdata_r;
  assign out_ch.irq_pulses = out_irq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsync_div_r <= HSYNC_DIV_RESET;
    end else if (cfg_ch.valid) begin
      hsync_div_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r      <= in_ch.op;
      s1_channel_r <= in_ch.channel;
      s1_wval_r    <= in_ch.write_value;
    end
  end

  // Processing of the registered beat: a tick advances all three channels
  // side by side (a disabled channel 2 holds), an access touches only the addressed channel.
  always_comb begin
    logic [15:0]   rate;
    logic [16:0]   phase_inc;
    logic [VW:0]   cnt1;
    logic [VW-1:0] load_v;
    logic          tgt_hit;
    logic          pulse;
    for (int i = 0; i < NUM_CH; i++) begin
      count_nxt[i]  = count_r[i];
      phase_nxt[i]  = phase_r[i];
      mode_nxt[i]   = mode_r[i];
      target_nxt[i] = target_r[i];
      toward_nxt[i] = toward_r[i];
      fired_nxt[i]  = fired_r[i];
    end
    rdata_nxt = '0;
    irq_nxt   = '0;
    load_v    = '0;
    rate      = 16'd1;
    phase_inc = '0;
    cnt1      = '0;
    tgt_hit   = 1'b0;
    pulse     = 1'b0;

    if (op_t'(s1_op_r) == OP_TICK) begin
      for (int i = 0; i < NUM_CH; i++) begin
        // Ticks per count step, selected by the mode word.
        if (i == 0) begin
          rate = mode_r[i][MB_RATE0] ? RATE_CH0_DIV : 16'd1;
        end else if (i == 1) begin
          rate = (mode_r[i][MB_RATE0] && (hsync_div_r != '0)) ? hsync_div_r : 16'd1;
        end else begin
          rate = mode_r[i][MB_RATE2] ? RATE_CH2_DIV : 16'd1;
        end
        phase_inc = {1'b0, phase_r[i]} + 17'd1;
        cnt1      = {1'b0, count_r[i]} + {{VW{1'b0}}, 1'b1};
        pulse     = 1'b0;
        tgt_hit   = toward_r[i] && (cnt1 >= (VW+1)'(target_r[i]));

        if ((i == 2) && mode_r[i][MB_DISABLE]) begin
          // Channel 2 frozen while disabled.
        end else if (phase_inc < {1'b0, rate}) begin
          phase_nxt[i] = phase_inc[15:0];
        end else begin
          phase_nxt[i] = '0;
          if (tgt_hit) begin
            mode_nxt[i][MB_EVENT]     = 1'b1;
            mode_nxt[i][MB_EQ_TARGET] = 1'b1;
            if (mode_r[i][MB_TO_TARGET]) begin
              cnt1 = '0;
            end else begin
              toward_nxt[i] = 1'b0;
            end
            if (mode_r[i][MB_IRQ_TARGET] && (mode_r[i][MB_REGEN] || !fired_r[i])) begin
              fired_nxt[i] = 1'b1;
              pulse        = 1'b1;
            end
          end
          // Overflow also follows a target hit that left the count at the
          // wrap point, and then sees the interrupt state the hit left.
          if (!toward_nxt[i] && (cnt1 >= LIMIT)) begin
            mode_nxt[i][MB_EVENT]    = 1'b1;
            mode_nxt[i][MB_OVERFLOW] = 1'b1;
            cnt1          = '0;
            toward_nxt[i] = (target_r[i] != '0);
            if (mode_r[i][MB_IRQ_OVF] && (mode_r[i][MB_REGEN] || !fired_nxt[i])) begin
              fired_nxt[i] = 1'b1;
              pulse        = 1'b1;
            end
          end
          count_nxt[i] = cnt1[VW-1:0];
        end
        irq_nxt[i] = pulse;
      end
    end else if (s1_channel_r != CH_UNUSED) begin
      unique case (op_t'(s1_op_r))
        OP_WRITE_COUNT: begin
          load_v = VW'(s1_wval_r) & CNT_MASK;
          count_nxt[s1_channel_r]  = load_v;
          phase_nxt[s1_channel_r]  = '0;
          toward_nxt[s1_channel_r] = load_v < VW'(target_r[s1_channel_r]);
        end
        OP_WRITE_MODE: begin
          mode_nxt[s1_channel_r]   = s1_wval_r;
          count_nxt[s1_channel_r]  = '0;
          phase_nxt[s1_channel_r]  = '0;
          fired_nxt[s1_channel_r]  = 1'b0;
          toward_nxt[s1_channel_r] = (target_r[s1_channel_r] != '0);
        end
        OP_WRITE_TARGET: begin
          load_v = count_r[s1_channel_r] & CNT_MASK;
          target_nxt[s1_channel_r] = s1_wval_r;
          count_nxt[s1_channel_r]  = load_v;
          phase_nxt[s1_channel_r]  = '0;
          toward_nxt[s1_channel_r] = load_v < VW'(s1_wval_r);
        end
        OP_READ_COUNT: begin
          rdata_nxt = count_r[s1_channel_r][15:0];
        end
        OP_READ_MODE: begin
          rdata_nxt = mode_r[s1_channel_r];
          mode_nxt[s1_channel_r] = mode_r[s1_channel_r] & MODE_READ_CLEAR;
        end
        OP_READ_TARGET: begin
          rdata_nxt = target_r[s1_channel_r];
        end
        default: begin
          // The unused operation code does nothing and reads zero.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        count_r[i]  <= '0;
        phase_r[i]  <= '0;
        mode_r[i]   <= '0;
        target_r[i] <= '0;
        toward_r[i] <= 1'b0;
        fired_r[i]  <= 1'b0;
      end
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        for (int i = 0; i < NUM_CH; i++) begin
          count_r[i]  <= count_nxt[i];
          phase_r[i]  <= phase_nxt[i];
          mode_r[i]   <= mode_nxt[i];
          target_r[i] <= target_nxt[i];
          toward_r[i] <= toward_nxt[i];
          fired_r[i]  <= fired_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_rdata_r <= rdata_nxt;
      out_irq_r   <= irq_nxt;
    end
  end

endmodule

// ===== tb/tb_root_counter_timer_block_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Root counter timer block testbench
// Drives register accesses and ticks through the valid/ready input channel,
// mirrors the three timer channels in a behavioral model and checks every
// result beat against it. The hsync divider is reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_root_counter_timer_block_top;
  import rct_pkg::*;

  localparam int unsigned COUNT_BITS = 16;
  localparam longint unsigned COUNT_LIMIT = 64'd1 << COUNT_BITS;

  // The op code that the package leaves unassigned; the block must ignore it.
  localparam logic [2:0] OP_NONE = 3'd7;

  // Cycles to let pass after the last result before touching the divider.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Receiver hold-off used to back the block up into its input channel.
  localparam int unsigned LONG_HOLD = 60;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 5000;
  // Least number of random beats queued per phase.
  localparam int unsigned PHASE_BEATS = 230;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  chan;
    logic [15:0] value;
  } timer_access_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [2:0]  irq;
  } timer_reply_t;

  logic clk;
  logic rst_n;

  rct_in_if  in_if ();
  rct_out_if out_if ();
  rct_cfg_if cfg_if ();

  root_counter_timer_block_top #(
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always #1 clk = ~clk;

  // Accesses waiting to be offered, and the replies the model expects back.
  timer_access_t access_q[$];
  timer_reply_t  reply_q[$];
  timer_access_t offered;

  int unsigned beats_queued;
  int unsigned beats_accepted;
  int unsigned mismatches;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned quiet_cycles;
  int unsigned hold_req_cnt;
  int unsigned hold_seen_cnt;
  bit          gaps_on;

  logic [15:0] divider_plan [0:4];

  // --------------------------------------------------------------------------
  // Timer model state. It mirrors the block channel for channel and is
  // advanced once per accepted input beat.
  // --------------------------------------------------------------------------
  longint unsigned tm_count [NUM_CH];
  int unsigned     tm_phase [NUM_CH];
  logic [15:0]     tm_mode  [NUM_CH];
  logic [15:0]     tm_target[NUM_CH];
  bit              tm_toward[NUM_CH];
  bit              tm_fired [NUM_CH];
  logic [15:0]     tm_hsync_div;

  function automatic logic [15:0] mbit(input int unsigned pos);
    return 16'(1) << pos;
  endfunction

  // A count load clears the prescaler and picks the direction from the target.
  function automatic void reload_timer(input int ch, input longint unsigned v);
    tm_count[ch] = v & (COUNT_LIMIT - 1);
    tm_phase[ch] = 0;
    tm_toward[ch] = tm_count[ch] < tm_target[ch];
  endfunction

  // Without the regenerate bit an interrupt fires only once per mode write.
  function automatic bit raise_timer_irq(input int ch, input int unsigned en_bit);
    if (tm_mode[ch][en_bit] && (tm_mode[ch][MB_REGEN] || !tm_fired[ch])) begin
      tm_fired[ch] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic timer_reply_t timer_model_step(input timer_access_t a);
    timer_reply_t r;
    int unsigned  div;
    r = '0;
    if (a.op == OP_TICK) begin
      for (int i = 0; i < NUM_CH; i++) begin
        // A disabled channel 2 keeps both its count and its prescaler.
        if (!(i == 2 && tm_mode[2][MB_DISABLE])) begin
          div = 1;
          if (i == 0 && tm_mode[0][MB_RATE0]) div = RATE_CH0_DIV;
          if (i == 1 && tm_mode[1][MB_RATE0]) div = (tm_hsync_div == 0) ? 1 : tm_hsync_div;
          if (i == 2 && tm_mode[2][MB_RATE2]) div = RATE_CH2_DIV;
          // A divider lowered below the phase reached completes the step now.
          if (tm_phase[i] + 1 < div) begin
            tm_phase[i]++;
          end else begin
            tm_phase[i] = 0;
            tm_count[i]++;
            if (tm_toward[i] && tm_count[i] >= tm_target[i]) begin
              tm_mode[i][MB_EVENT] = 1'b1;
              if (tm_mode[i][MB_TO_TARGET]) tm_count[i] = 0;
              else tm_toward[i] = 1'b0;
              if (raise_timer_irq(i, MB_IRQ_TARGET)) r.irq[i] = 1'b1;
              tm_mode[i][MB_EQ_TARGET] = 1'b1;
            end
            if (!tm_toward[i] && tm_count[i] >= COUNT_LIMIT) begin
              tm_mode[i][MB_EVENT] = 1'b1;
              tm_count[i] = 0;
              if (tm_target[i] != 0) tm_toward[i] = 1'b1;
              if (raise_timer_irq(i, MB_IRQ_OVF)) r.irq[i] = 1'b1;
              tm_mode[i][MB_OVERFLOW] = 1'b1;
            end
          end
        end
      end
    end else if (a.chan != CH_UNUSED) begin
      case (a.op)
        OP_WRITE_COUNT: begin
          reload_timer(a.chan, a.value);
        end
        OP_WRITE_MODE: begin
          tm_mode[a.chan] = a.value;
          reload_timer(a.chan, 0);
          tm_fired[a.chan] = 1'b0;
        end
        OP_WRITE_TARGET: begin
          tm_target[a.chan] = a.value;
          reload_timer(a.chan, tm_count[a.chan]);
        end
        OP_READ_COUNT: begin
          r.read_data = tm_count[a.chan][15:0];
        end
        OP_READ_MODE: begin
          r.read_data = tm_mode[a.chan];
          tm_mode[a.chan] &= MODE_READ_CLEAR;
        end
        OP_READ_TARGET: begin
          r.read_data = tm_target[a.chan];
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  // Most gaps are short, a few are long, and many beats get none at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  task automatic push_access(input logic [2:0] op, input logic [1:0] chan,
                             input logic [15:0] value);
    access_q.push_back('{op: op, chan: chan, value: value});
    beats_queued++;
  endtask

  // Random timer setups: a mode, a target and a count chosen so that target
  // and overflow events actually show up, followed by a burst of ticks with
  // reads mixed in. About one pick in seven is a single beat of plain noise.
  task automatic queue_random_accesses(input int unsigned budget);
    int unsigned    start;
    int unsigned    r;
    logic [1:0]     ch;
    logic [15:0]    m;
    logic [15:0]    t;
    logic [15:0]    c;
    start = beats_queued;
    while (beats_queued - start < budget) begin
      if ($urandom_range(0, 99) < 15) begin
        push_access(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                    16'($urandom_range(0, 65535)));
      end else begin
        ch = 2'($urandom_range(0, 2));
        m = 16'($urandom);
        if (ch == 2 && $urandom_range(0, 4) != 0) m[MB_DISABLE] = 1'b0;
        // The hsync rate can be very slow, so it is chosen only now and then.
        if (ch == 1 && $urandom_range(0, 2) != 0) m[MB_RATE0] = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 25) t = 16'h0000;
        else if (r < 75) t = 16'($urandom_range(1, 12));
        else if (r < 90) t = 16'($urandom);
        else t = 16'hffff;
        r = $urandom_range(0, 99);
        if (r < 40) c = (t > 4) ? t - 16'($urandom_range(1, 4)) : 16'h0000;
        else if (r < 75) c = 16'hffff - 16'($urandom_range(0, 6));
        else c = 16'($urandom);
        push_access(OP_WRITE_MODE, ch, m);
        push_access(OP_WRITE_TARGET, ch, t);
        push_access(OP_WRITE_COUNT, ch, c);
        repeat ($urandom_range(4, 24)) begin
          if ($urandom_range(0, 4) == 0)
            push_access(3'($urandom_range(OP_READ_COUNT, OP_READ_TARGET)),
                        2'($urandom_range(0, 2)), 16'($urandom));
          push_access(OP_TICK, 2'($urandom_range(0, 3)), 16'($urandom));
        end
        push_access(OP_READ_MODE, ch, 16'($urandom));
        push_access(OP_READ_COUNT, ch, 16'($urandom));
      end
    end
  endtask

  // Blocks until every queued access has been accepted and answered, then
  // lets the pipeline settle so the divider can be changed safely.
  task automatic wait_drained();
    while (beats_accepted != beats_queued || reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The divider is written only while the block is idle, so the model can
  // take the new value at the moment of the handshake.
  task automatic write_hsync_divider(input logic [15:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    tm_hsync_div = v;
  endtask

  // --------------------------------------------------------------------------
  // Input driver. On an accepted beat the model is advanced and its reply is
  // queued. A beat that is not yet taken is held steady; otherwise either a
  // gap is inserted or the next access is put on the channel.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        reply_q.push_back(timer_model_step(offered));
        beats_accepted++;
        send_gap = pick_gap();
      end
      if (in_if.valid && !in_if.ready) begin
        // The beat stays on the channel until it is taken.
      end else if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (access_q.size() > 0) begin
        offered = access_q.pop_front();
        in_if.valid       <= 1'b1;
        in_if.op          <= offered.op;
        in_if.channel     <= offered.chan;
        in_if.write_value <= offered.value;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Every accepted beat is checked against the oldest reply
  // the model produced. The ready line is dropped at random, and for a long
  // stretch whenever the stimulus asks for back pressure.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    timer_reply_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: result beat with no access outstanding, read_data %h irq %b",
                   $time, out_if.read_data, out_if.irq_pulses);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (out_if.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch, expected %h, got %h",
                     $time, want.read_data, out_if.read_data);
            mismatches++;
          end
          if (out_if.irq_pulses !== want.irq) begin
            $display("%0t: irq_pulses mismatch, expected %b, got %b",
                     $time, want.irq, out_if.irq_pulses);
            mismatches++;
          end
        end
        recv_stall = pick_gap();
      end
      if (hold_seen_cnt != hold_req_cnt) begin
        hold_seen_cnt++;
        recv_stall = LONG_HOLD;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Hang detection: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_TICK;
    in_if.channel = 2'd0;
    in_if.write_value = 16'h0000;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = 16'h0000;
    gaps_on = 1'b1;
    beats_queued = 0;
    beats_accepted = 0;
    mismatches = 0;
    hold_req_cnt = 0;
    hold_seen_cnt = 0;
    quiet_cycles = 0;
    for (int i = 0; i < NUM_CH; i++) begin
      tm_count[i] = 0;
      tm_phase[i] = 0;
      tm_mode[i] = 16'h0000;
      tm_target[i] = 16'h0000;
      tm_toward[i] = 1'b0;
      tm_fired[i] = 1'b0;
    end
    tm_hsync_div = HSYNC_DIV_RESET;
    divider_plan[0] = 16'd1;
    divider_plan[1] = 16'd7;
    divider_plan[2] = 16'hffff;
    divider_plan[3] = HSYNC_DIV_RESET;
    divider_plan[4] = 16'd3;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Channel 0 with a zero target only overflows; starting at
    // the top count the first tick wraps it and fires the one-shot interrupt.
    push_access(OP_READ_MODE, 2'd0, 16'h0000);
    push_access(OP_WRITE_MODE, 2'd0, mbit(MB_IRQ_TARGET) | mbit(MB_IRQ_OVF));
    push_access(OP_WRITE_TARGET, 2'd0, 16'h0000);
    push_access(OP_WRITE_COUNT, 2'd0, 16'hffff);
    push_access(OP_TICK, 2'd0, 16'h0000);
    push_access(OP_TICK, 2'd3, 16'hffff);
    // The first mode read shows the sticky bits, the second finds them cleared.
    push_access(OP_READ_MODE, 2'd0, 16'h0000);
    push_access(OP_READ_MODE, 2'd0, 16'h0000);
    // Channel 2 with its disable bit set must not move at all.
    push_access(OP_WRITE_MODE, 2'd2, mbit(MB_DISABLE) | mbit(MB_TO_TARGET) |
                mbit(MB_IRQ_TARGET) | mbit(MB_REGEN));
    push_access(OP_WRITE_TARGET, 2'd2, 16'd2);
    push_access(OP_TICK, 2'd0, 16'h0000);
    push_access(OP_TICK, 2'd0, 16'h0000);
    push_access(OP_READ_COUNT, 2'd2, 16'h0000);
    // Enabled again, counting to target with regenerate fires on every wrap.
    push_access(OP_WRITE_MODE, 2'd2, mbit(MB_TO_TARGET) | mbit(MB_IRQ_TARGET) | mbit(MB_REGEN));
    push_access(OP_WRITE_TARGET, 2'd2, 16'd2);
    repeat (4) push_access(OP_TICK, 2'd1, 16'h0000);
    push_access(OP_READ_TARGET, 2'd2, 16'h0000);
    // Accesses to the unused channel and the unused op do nothing.
    push_access(OP_WRITE_COUNT, CH_UNUSED, 16'hffff);
    push_access(OP_READ_COUNT, CH_UNUSED, 16'hffff);
    push_access(OP_NONE, 2'd1, 16'hffff);
    push_access(OP_READ_COUNT, 2'd1, 16'h0000);
    // Every mode bit set at once, including the hsync clock on channel 1.
    push_access(OP_WRITE_MODE, 2'd1, 16'hffff);
    push_access(OP_READ_MODE, 2'd1, 16'h0000);
    wait_drained();

    // Random phases, one divider setting each. The second phase runs without
    // any idling, the third starts with a long receiver hold-off so the block
    // backs up while the driver keeps offering beats.
    for (int p = 0; p < 5; p++) begin
      write_hsync_divider(divider_plan[p]);
      gaps_on <= (p != 1);
      if (p == 2) hold_req_cnt <= hold_req_cnt + 1;
      queue_random_accesses(PHASE_BEATS);
      wait_drained();
    end

    // Divider lowered: channel 1 runs part way through a slow hsync step,
    // then the divider drops below the phase reached and the next tick must
    // complete the step.
    gaps_on <= 1'b1;
    write_hsync_divider(16'd40);
    push_access(OP_WRITE_MODE, 2'd1, mbit(MB_RATE0) | mbit(MB_IRQ_OVF));
    repeat (25) push_access(OP_TICK, 2'd0, 16'h0000);
    push_access(OP_READ_COUNT, 2'd1, 16'h0000);
    wait_drained();
    write_hsync_divider(16'd2);
    push_access(OP_TICK, 2'd0, 16'h0000);
    push_access(OP_READ_COUNT, 2'd1, 16'h0000);
    repeat (3) push_access(OP_TICK, 2'd0, 16'h0000);
    push_access(OP_READ_COUNT, 2'd1, 16'h0000);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
